>>> hdl/cbd_pkg.sv
package cbd_pkg;

    // Request kinds.
    localparam logic [1:0] REQ_READ = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_PUSH = 2'd2;
    localparam logic [1:0] REQ_PULL = 2'd3;

    // Target codes.
    localparam logic [2:0] TGT_RAM = 3'd0;
    localparam logic [2:0] TGT_PPU = 3'd1;
    localparam logic [2:0] TGT_DMA = 3'd2;
    localparam logic [2:0] TGT_PAD = 3'd3;
    localparam logic [2:0] TGT_MAP = 3'd4;
    localparam logic [2:0] TGT_NONE = 3'd5;

    // Bus map.
    localparam logic [15:0] ADDR_STACK = 16'h0100;
    localparam logic [15:0] ADDR_PPU = 16'h2000;
    localparam logic [15:0] ADDR_IO = 16'h4000;
    localparam logic [15:0] ADDR_DMA = 16'h4014;
    localparam logic [15:0] ADDR_PAD_ONE = 16'h4016;
    localparam logic [15:0] ADDR_PAD_TWO = 16'h4017;
    localparam logic [15:0] ADDR_MAPPER = 16'h6000;
    localparam logic [7:0] OPEN_BUS_BYTE = 8'hDE;

    localparam logic [3:0] PAD_BITS = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  stack_ptr;
        logic [7:0]  pad_one_buttons;
        logic [7:0]  pad_two_buttons;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  target;
        logic [15:0] target_address;
        logic        target_is_write;
        logic [7:0]  new_stack_ptr;
    } t_res;

    // Decoded access, passed from the decoder to the datapath and pad ports.
    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] target_address;
        logic        is_write;
        logic [7:0]  new_sp;
        logic [7:0]  stack_sp;
        logic        ram_rd;
        logic        ram_wr;
        logic        ram_stack;
        logic        pad_rd_one;
        logic        pad_rd_two;
        logic        pad_wr;
        logic [7:0]  read_data;
    } t_dec;

endpackage

>>> hdl/cpu_bus_decoder_ram_pads.sv
// A result strobes on o_strobe in the cycle after its item is accepted.
// Throughput: one item per cycle unless busy; each RAM item accesses the RAM once.
// Reset: synchronous, active low. After reset the block fills the work RAM with its
// power-up pattern, one byte a cycle, holding busy high until the pass ends.
// The receiver cannot stall; every result is shown for exactly one cycle.
module cpu_bus_decoder_ram_pads import cbd_pkg::*; #(
    parameter int RAM_BYTES = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [13:0] RamSize = 14'(RAM_BYTES);
    localparam logic [AW-1:0] LastIdx = AW'(RAM_BYTES - 1);

    // Bus addresses below 0x2000 mirror the work RAM. The operand is under
    // 8192 and the size is at least 2048, so three conditional subtractions
    // reduce it fully.
    function automatic logic [AW-1:0] ram_mirror(input logic [12:0] addr);
        logic [13:0] val;
        val = {1'b0, addr};
        for (int k = 0; k < 3; k++) begin
            if (val >= RamSize) begin
                val = val - RamSize;
            end
        end
        return val[AW-1:0];
    endfunction

    // Power-up contents: four-byte groups alternate between 0x00 and 0xFF,
    // and the stack page is all ones.
    function automatic logic [7:0] fill_byte(input logic [AW-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        if (wide >= 32'h100 && wide < 32'h200) begin
            return 8'hFF;
        end
        return idx[2] ? 8'hFF : 8'h00;
    endfunction

    logic          accept;
    t_dec          dec;
    logic          pad_bit;
    logic [AW-1:0] bus_idx;
    logic [AW-1:0] item_idx;

    logic          r_clearing;
    logic          n_clearing;
    logic [AW-1:0] r_clr_cnt;
    logic [AW-1:0] n_clr_cnt;

    logic          r_strobe;
    logic          r_from_ram;
    logic [7:0]    r_rd;
    t_res          r_res;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign accept = start && !busy;
    assign busy = r_clearing;

    cbd_decode u_decode (
        .i_req (i_req),
        .o_dec (dec)
    );

    cbd_pads u_pads (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_dec       (dec),
        .i_write_bit (i_req.write_data[0]),
        .i_pad_one   (i_req.pad_one_buttons),
        .i_pad_two   (i_req.pad_two_buttons),
        .o_bit       (pad_bit)
    );

    // Stack accesses sit in page one, which every legal RAM size contains.
    assign bus_idx = ram_mirror(i_req.address[12:0]);
    assign item_idx = dec.ram_stack ? AW'({1'b1, dec.stack_sp}) : bus_idx;

    // The clearing pass owns the RAM port; items are held off by busy meanwhile.
    assign ram_we = i_rst_n && (r_clearing || (accept && dec.ram_wr));
    assign ram_re = accept && dec.ram_rd;
    assign ram_addr = r_clearing ? r_clr_cnt : item_idx;
    assign ram_wdata = r_clearing ? fill_byte(r_clr_cnt) : i_req.write_data;

    cbd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_clearing = r_clearing;
        n_clr_cnt = r_clr_cnt;
        if (r_clearing) begin
            n_clr_cnt = r_clr_cnt + AW'(1);
            if (r_clr_cnt == LastIdx) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_cnt <= n_clr_cnt;
            r_strobe <= accept;
        end
    end

    // Everything but the RAM byte is settled at acceptance and registered here;
    // the RAM byte arrives from the memory's read register in the next cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_from_ram <= dec.ram_rd;
            r_rd <= (dec.pad_rd_one || dec.pad_rd_two) ? {7'd0, pad_bit} : dec.read_data;
            r_res.read_data <= '0;
            r_res.target <= dec.target;
            r_res.target_address <= (dec.target == TGT_RAM && !dec.ram_stack)
                ? 16'(bus_idx) : dec.target_address;
            r_res.target_is_write <= dec.is_write;
            r_res.new_stack_ptr <= dec.new_sp;
        end
    end

    always_comb begin
        o_res = r_res;
        o_res.read_data = r_from_ram ? ram_rdata : r_rd;
    end

    assign o_strobe = r_strobe;

`ifndef ASSERT_OFF
    // A result follows every accepted item in the next cycle, and no other.
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_strobe == $past(start && !busy)))
        else $error("result strobe does not match accepted item");

    // No result can appear while the RAM is still being filled.
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown during clearing pass");

    // The clearing pass ends only after writing the last RAM entry.
    a_clear_covers_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> ($past(r_clr_cnt) == LastIdx))
        else $error("clearing pass ended early");
`endif

endmodule

>>> hdl/cbd_ram.sv
module cbd_ram import cbd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cbd_decode.sv
module cbd_decode import cbd_pkg::*; (
    input  t_req i_req,
    output t_dec o_dec
);

    logic [7:0] sp_dec;
    logic [7:0] sp_inc;

    assign sp_dec = i_req.stack_ptr - 8'd1;
    assign sp_inc = i_req.stack_ptr + 8'd1;

    always_comb begin
        o_dec = '0;
        o_dec.target = TGT_NONE;
        o_dec.target_address = i_req.address;
        o_dec.new_sp = i_req.stack_ptr;
        o_dec.stack_sp = i_req.stack_ptr;
        case (i_req.req_type)
            REQ_PUSH: begin
                o_dec.target = TGT_RAM;
                o_dec.target_address = ADDR_STACK | {8'h00, i_req.stack_ptr};
                o_dec.is_write = 1'b1;
                o_dec.new_sp = sp_dec;
                o_dec.ram_wr = 1'b1;
                o_dec.ram_stack = 1'b1;
            end
            REQ_PULL: begin
                o_dec.target = TGT_RAM;
                o_dec.target_address = ADDR_STACK | {8'h00, sp_inc};
                o_dec.new_sp = sp_inc;
                o_dec.stack_sp = sp_inc;
                o_dec.ram_rd = 1'b1;
                o_dec.ram_stack = 1'b1;
            end
            REQ_WRITE: begin
                o_dec.is_write = 1'b1;
                if (i_req.address < ADDR_PPU) begin
                    o_dec.target = TGT_RAM;
                    o_dec.ram_wr = 1'b1;
                end else if (i_req.address < ADDR_IO) begin
                    o_dec.target = TGT_PPU;
                    o_dec.target_address = ADDR_PPU | {13'd0, i_req.address[2:0]};
                end else if (i_req.address == ADDR_DMA) begin
                    o_dec.target = TGT_DMA;
                end else if (i_req.address == ADDR_PAD_ONE) begin
                    o_dec.target = TGT_PAD;
                    o_dec.pad_wr = 1'b1;
                end else if (i_req.address >= ADDR_MAPPER) begin
                    o_dec.target = TGT_MAP;
                end
            end
            default: begin
                if (i_req.address < ADDR_PPU) begin
                    o_dec.target = TGT_RAM;
                    o_dec.ram_rd = 1'b1;
                end else if (i_req.address < ADDR_IO) begin
                    o_dec.target = TGT_PPU;
                    o_dec.target_address = ADDR_PPU | {13'd0, i_req.address[2:0]};
                end else if (i_req.address == ADDR_DMA) begin
                    o_dec.target = TGT_DMA;
                end else if (i_req.address == ADDR_PAD_ONE) begin
                    o_dec.target = TGT_PAD;
                    o_dec.pad_rd_one = 1'b1;
                end else if (i_req.address == ADDR_PAD_TWO) begin
                    o_dec.target = TGT_PAD;
                    o_dec.pad_rd_two = 1'b1;
                end else if (i_req.address >= ADDR_MAPPER) begin
                    o_dec.target = TGT_MAP;
                end else begin
                    o_dec.read_data = OPEN_BUS_BYTE;
                end
            end
        endcase
    end

endmodule

>>> hdl/cbd_pads.sv
module cbd_pads import cbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_dec       i_dec,
    input  logic       i_write_bit,
    input  logic [7:0] i_pad_one,
    input  logic [7:0] i_pad_two,
    output logic       o_bit
);

    logic       r_strobe;
    logic       n_strobe;
    logic [3:0] r_idx_one;
    logic [3:0] n_idx_one;
    logic [3:0] r_idx_two;
    logic [3:0] n_idx_two;

    // Shift one button bit out; the index stops at eight.
    always_comb begin
        n_strobe = r_strobe;
        n_idx_one = r_idx_one;
        n_idx_two = r_idx_two;
        o_bit = 1'b0;
        if (i_dec.pad_rd_one) begin
            if (r_idx_one < PAD_BITS) begin
                o_bit = i_pad_one[r_idx_one[2:0]];
                n_idx_one = r_idx_one + 4'd1;
            end
            if (r_strobe) begin
                n_idx_one = '0;
            end
        end
        if (i_dec.pad_rd_two) begin
            if (r_idx_two < PAD_BITS) begin
                o_bit = i_pad_two[r_idx_two[2:0]];
                n_idx_two = r_idx_two + 4'd1;
            end
            if (r_strobe) begin
                n_idx_two = '0;
            end
        end
        if (i_dec.pad_wr) begin
            n_strobe = i_write_bit;
            if (i_write_bit) begin
                n_idx_one = '0;
                n_idx_two = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_idx_one <= '0;
            r_idx_two <= '0;
        end else if (i_accept) begin
            r_strobe <= n_strobe;
            r_idx_one <= n_idx_one;
            r_idx_two <= n_idx_two;
        end
    end

endmodule

>>> dv/tb_cpu_bus_decoder_ram_pads.sv
`timescale 1ns / 1ps

module tb_cpu_bus_decoder_ram_pads;
    import cbd_pkg::*;

    localparam int RAM_BYTES = 8192;
    // The work RAM fill after reset alone keeps the block busy until all RAM_BYTES
    // entries are written, so the watchdog has to sit well above that.
    localparam int WATCHDOG_LIMIT = 40000;
    // Results come in the cycle after acceptance; DRAIN_CYCLES adds margin at the end.
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS = 40;
    localparam int ITEMS_PER_PHASE = 575;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    // Shadow copy of the block's state, advanced once per accepted item.
    logic [7:0] shadow_ram [RAM_BYTES];
    logic       shadow_strobe;
    logic [3:0] shadow_pad_one_index;
    logic [3:0] shadow_pad_two_index;

    // Results predicted for accepted items, oldest first.
    t_res pending_results[$];

    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    // Running stack pointer, so that random pulls read back what pushes stored.
    logic [7:0] stack_cursor = 8'hFD;

    cpu_bus_decoder_ram_pads #(
        .RAM_BYTES(RAM_BYTES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_strobe(o_strobe),
        .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Power-up contents: four-byte groups alternate 0x00 and 0xFF, and the stack
    // page 0x100..0x1FF is all 0xFF.
    function automatic void clear_shadow();
        for (int i = 0; i < RAM_BYTES; i++) begin
            if (i >= 'h100 && i < 'h200) begin
                shadow_ram[i] = 8'hFF;
            end else begin
                shadow_ram[i] = ((i >> 2) & 1) ? 8'hFF : 8'h00;
            end
        end
        shadow_strobe = 1'b0;
        shadow_pad_one_index = 4'd0;
        shadow_pad_two_index = 4'd0;
    endfunction

    // A controller read shows the button at the current index, or zero once the
    // index has run out at eight.
    function automatic logic [7:0] pad_bit(input logic [3:0] idx, input logic [7:0] buttons);
        return (idx < PAD_BITS) ? {7'd0, buttons[idx[2:0]]} : 8'd0;
    endfunction

    // The index saturates at eight; a set strobe holds it at zero.
    function automatic logic [3:0] next_pad_index(input logic [3:0] idx);
        if (shadow_strobe) begin
            return 4'd0;
        end
        return (idx < PAD_BITS) ? idx + 4'd1 : idx;
    endfunction

    // Decodes one bus access against the shadow state and returns its result.
    function automatic t_res predict_access(input t_req req);
        t_res res;
        int   ram_index;
        logic [7:0] sp_after;
        res.read_data = 8'd0;
        res.target = TGT_NONE;
        res.target_address = req.address;
        res.target_is_write = 1'b0;
        res.new_stack_ptr = req.stack_ptr;
        ram_index = int'(req.address) % RAM_BYTES;
        case (req.req_type)
            REQ_PUSH: begin
                res.target_address = ADDR_STACK + {8'h00, req.stack_ptr};
                shadow_ram[int'(res.target_address) % RAM_BYTES] = req.write_data;
                res.new_stack_ptr = req.stack_ptr - 8'd1;
                res.target = TGT_RAM;
                res.target_is_write = 1'b1;
            end
            REQ_PULL: begin
                sp_after = req.stack_ptr + 8'd1;
                res.new_stack_ptr = sp_after;
                res.target_address = ADDR_STACK + {8'h00, sp_after};
                res.read_data = shadow_ram[int'(res.target_address) % RAM_BYTES];
                res.target = TGT_RAM;
            end
            REQ_WRITE: begin
                res.target_is_write = 1'b1;
                if (req.address < ADDR_PPU) begin
                    res.target_address = ram_index[15:0];
                    shadow_ram[ram_index] = req.write_data;
                    res.target = TGT_RAM;
                end else if (req.address < ADDR_IO) begin
                    res.target_address = ADDR_PPU + {13'd0, req.address[2:0]};
                    res.target = TGT_PPU;
                end else if (req.address == ADDR_DMA) begin
                    res.target = TGT_DMA;
                end else if (req.address == ADDR_PAD_ONE) begin
                    shadow_strobe = req.write_data[0];
                    if (shadow_strobe) begin
                        shadow_pad_one_index = 4'd0;
                        shadow_pad_two_index = 4'd0;
                    end
                    res.target = TGT_PAD;
                end else if (req.address >= ADDR_MAPPER) begin
                    res.target = TGT_MAP;
                end
            end
            default: begin
                if (req.address < ADDR_PPU) begin
                    res.target_address = ram_index[15:0];
                    res.read_data = shadow_ram[ram_index];
                    res.target = TGT_RAM;
                end else if (req.address < ADDR_IO) begin
                    res.target_address = ADDR_PPU + {13'd0, req.address[2:0]};
                    res.target = TGT_PPU;
                end else if (req.address == ADDR_DMA) begin
                    res.target = TGT_DMA;
                end else if (req.address == ADDR_PAD_ONE) begin
                    res.read_data = pad_bit(shadow_pad_one_index, req.pad_one_buttons);
                    shadow_pad_one_index = next_pad_index(shadow_pad_one_index);
                    res.target = TGT_PAD;
                end else if (req.address == ADDR_PAD_TWO) begin
                    res.read_data = pad_bit(shadow_pad_two_index, req.pad_two_buttons);
                    shadow_pad_two_index = next_pad_index(shadow_pad_two_index);
                    res.target = TGT_PAD;
                end else if (req.address >= ADDR_MAPPER) begin
                    res.target = TGT_MAP;
                end else begin
                    res.read_data = OPEN_BUS_BYTE;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // Compares one result from the block with the oldest prediction, field by field.
    task automatic check_result(input t_res got);
        t_res exp;
        if (pending_results.size() == 0) begin
            report_mismatch("result strobed with no item outstanding");
        end else begin
            exp = pending_results.pop_front();
            if (got.read_data !== exp.read_data)
                report_mismatch($sformatf("read_data %h, expected %h",
                                          got.read_data, exp.read_data));
            if (got.target !== exp.target)
                report_mismatch($sformatf("target %0d, expected %0d",
                                          got.target, exp.target));
            if (got.target_address !== exp.target_address)
                report_mismatch($sformatf("target_address %h, expected %h",
                                          got.target_address, exp.target_address));
            if (got.target_is_write !== exp.target_is_write)
                report_mismatch($sformatf("target_is_write %b, expected %b",
                                          got.target_is_write, exp.target_is_write));
            if (got.new_stack_ptr !== exp.new_stack_ptr)
                report_mismatch($sformatf("new_stack_ptr %h, expected %h",
                                          got.new_stack_ptr, exp.new_stack_ptr));
        end
    endtask

    // Everything is sampled at the rising edge, before any nonblocking update of
    // that edge lands. A result strobed in the cycle just ended belongs to an item
    // accepted earlier, so it is checked before the item of this edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                check_result(o_res);
            end
            if (start && busy === 1'b0) begin
                pending_results.push_back(predict_access(i_req));
            end
        end
    end

    // Ends the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one item, after a random number of idle cycles, and returns at the
    // edge that accepts it. Start is left high so back-to-back items stream.
    task automatic send_access(input t_req req);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    function automatic t_req random_access();
        t_req r;
        r.req_type = 2'($urandom);
        r.address = 16'($urandom);
        r.write_data = 8'($urandom);
        r.stack_ptr = 8'($urandom);
        r.pad_one_buttons = 8'($urandom);
        r.pad_two_buttons = 8'($urandom);
        return r;
    endfunction

    task automatic send_fixed(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [7:0] data, input logic [7:0] sp);
        t_req r;
        r = random_access();
        r.req_type = kind;
        r.address = addr;
        r.write_data = data;
        r.stack_ptr = sp;
        send_access(r);
    endtask

    // Power-up pattern, the top of RAM, and a write read back at both ends.
    task automatic test_work_ram();
        send_fixed(REQ_READ, 16'h0000, 8'h00, 8'h00);
        send_fixed(REQ_READ, 16'h0004, 8'hFF, 8'hFF);
        send_fixed(REQ_READ, 16'h0150, 8'h00, 8'h00);
        send_fixed(REQ_WRITE, 16'h1FFF, 8'hFF, 8'h80);
        send_fixed(REQ_READ, 16'h1FFF, 8'h00, 8'h7F);
        send_fixed(REQ_WRITE, 16'h0004, 8'h00, 8'h01);
        send_fixed(REQ_READ, 16'h0004, 8'hA5, 8'hFE);
    endtask

    // PPU mirroring, DMA port, unmapped reads and writes, and the mapper at both ends.
    task automatic test_bus_targets();
        send_fixed(REQ_READ, ADDR_PPU, 8'h00, 8'h10);
        send_fixed(REQ_WRITE, 16'h3FFF, 8'h3C, 8'h20);
        send_fixed(REQ_READ, ADDR_DMA, 8'h00, 8'h30);
        send_fixed(REQ_WRITE, ADDR_DMA, 8'h02, 8'h40);
        send_fixed(REQ_READ, ADDR_IO, 8'h00, 8'h50);
        send_fixed(REQ_WRITE, ADDR_PAD_TWO, 8'h01, 8'h60);
        send_fixed(REQ_READ, 16'h5FFF, 8'h00, 8'h70);
        send_fixed(REQ_READ, ADDR_MAPPER, 8'h00, 8'h90);
        send_fixed(REQ_WRITE, 16'hFFFF, 8'hFF, 8'hA0);
    endtask

    // Strobe high pins the index at zero; after release the bits shift out.
    task automatic test_pad_ports();
        send_fixed(REQ_WRITE, ADDR_PAD_ONE, 8'h01, 8'h00);
        send_fixed(REQ_READ, ADDR_PAD_ONE, 8'h00, 8'h00);
        send_fixed(REQ_WRITE, ADDR_PAD_ONE, 8'hFE, 8'h00);
        send_fixed(REQ_READ, ADDR_PAD_ONE, 8'h00, 8'h00);
        send_fixed(REQ_READ, ADDR_PAD_TWO, 8'h00, 8'h00);
    endtask

    // Push at pointer zero wraps down to 0xFF; the pull from 0xFF wraps back and
    // reads the byte just pushed at 0x100.
    task automatic test_stack_wrap();
        send_fixed(REQ_PUSH, 16'hFFFF, 8'h5A, 8'h00);
        send_fixed(REQ_PULL, 16'h0000, 8'h00, 8'hFF);
    endtask

    // Start goes low and the sender holds off until every result is back.
    task automatic test_pause_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random traffic, mostly in well-formed sequences: RAM accesses clustered so
    // reads hit written bytes, push and pull runs around a moving pointer, and
    // controller strobe/read bursts long enough to saturate the index. The rest
    // covers the I/O window and fully random items.
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int   stop_at;
        int   pick;
        int   burst;
        t_req req;
        sender_idle_pct = idle_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            req = random_access();
            if (pick < 25) begin
                req.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
                req.address = $urandom_range(1) ? 16'($urandom_range(63))
                                                : 16'($urandom_range(16'h1FFF));
                send_access(req);
            end else if (pick < 45) begin
                req.req_type = $urandom_range(1) ? REQ_PUSH : REQ_PULL;
                if ($urandom_range(9) == 0) begin
                    stack_cursor = 8'($urandom);
                end
                req.stack_ptr = stack_cursor;
                stack_cursor = (req.req_type == REQ_PUSH) ? stack_cursor - 8'd1
                                                          : stack_cursor + 8'd1;
                send_access(req);
            end else if (pick < 65) begin
                req.req_type = REQ_WRITE;
                req.address = ADDR_PAD_ONE;
                req.write_data[0] = 1'b1;
                send_access(req);
                // Now and then the strobe is left set for the whole burst.
                if ($urandom_range(3) != 0) begin
                    req = random_access();
                    req.req_type = REQ_WRITE;
                    req.address = ADDR_PAD_ONE;
                    req.write_data[0] = 1'b0;
                    send_access(req);
                end
                burst = $urandom_range(1, 10);
                repeat (burst) begin
                    req = random_access();
                    req.req_type = REQ_READ;
                    req.address = $urandom_range(1) ? ADDR_PAD_TWO : ADDR_PAD_ONE;
                    send_access(req);
                end
            end else if (pick < 80) begin
                req.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
                case ($urandom_range(5))
                    0: req.address = 16'($urandom_range(16'h2000, 16'h3FFF));
                    1: req.address = ADDR_DMA;
                    2: req.address = ADDR_PAD_ONE;
                    3: req.address = ADDR_PAD_TWO;
                    4: req.address = 16'($urandom_range(16'h4000, 16'h5FFF));
                    default: req.address = 16'($urandom_range(16'h6000, 16'hFFFF));
                endcase
                send_access(req);
            end else begin
                send_access(req);
            end
        end
    endtask

    initial begin
        clear_shadow();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items go back to back; the first waits out the RAM fill.
        sender_idle_pct = 0;
        test_work_ram();
        test_bus_targets();
        test_pad_ports();
        test_stack_wrap();

        test_random_traffic(11, ITEMS_PER_PHASE);
        test_pause_until_drained();
        test_random_traffic(71, ITEMS_PER_PHASE);
        test_random_traffic(0, ITEMS_PER_PHASE);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
